>>> rtl/hrc_pkg.sv
// ----------------------------------------------------------------------------
// hrc_pkg: shared constants for the hierarchical resource charger
// Holds default sizes and the operation, severity and status codes.
// ----------------------------------------------------------------------------
package hrc_pkg;

    localparam int unsigned NumCounters  = 16;
    localparam int unsigned NumResources = 32;
    localparam int unsigned MaxDepth     = 4;

    localparam logic [2:0] MODE_CHARGE     = 3'd0;
    localparam logic [2:0] MODE_FORCE_NT   = 3'd1;
    localparam logic [2:0] MODE_UNCHARGE   = 3'd2;
    localparam logic [2:0] MODE_UNCH_NT    = 3'd3;
    localparam logic [2:0] MODE_SET_LIMITS = 3'd4;
    localparam logic [2:0] MODE_SET_PARENT = 3'd5;
    localparam logic [2:0] MODE_READ       = 3'd6;
    localparam logic [2:0] MODE_RSVD       = 3'd7;

    localparam logic [1:0] SEV_HARD   = 2'd0;
    localparam logic [1:0] SEV_SOFT   = 2'd1;
    localparam logic [1:0] SEV_FORCED = 2'd2;
    localparam logic [1:0] SEV_RSVD   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_CLAMPED = 2'd3;

    localparam logic [30:0] MASK31 = 31'h7FFF_FFFF;

endpackage

>>> rtl/hierarchical_resource_charger.sv
// ----------------------------------------------------------------------------
// hierarchical_resource_charger: hierarchical resource quota counters
// A table of per-counter, per-resource accounts with parent links. Charges
// and uncharges walk the ancestor chain with one shared read-modify-write
// datapath; refused charges are unrolled level by level.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake               | content
//  ---------+-----+-------------------------+------------------------------
//  s_axis   | in  | tvalid / tready         | one request (op and operands)
//  m_axis   | out | tvalid / tready         | one result per request
//  cfg      | in  | i_cfg_we                | max_value register
//
//  A request passes a decode state, then per visited chain level the read
//  address, read data and compare and write-back states, then the states
//  that read the entry for the result; a refused charge adds an unroll
//  state per level unrolled.
//  After reset a clearing pass writes every entry, one per cycle; no
//  request is taken during it.
//  The block is busy on one request at a time; s_axis_tready is low while a
//  request is in work or its result waits on m_axis.
//  The entry memories allow one registered read per cycle, which sets the
//  per-level cost.
// ----------------------------------------------------------------------------
module hierarchical_resource_charger #(
    parameter int unsigned NUM_COUNTERS  = hrc_pkg::NumCounters,
    parameter int unsigned NUM_RESOURCES = hrc_pkg::NumResources,
    parameter int unsigned MAX_DEPTH     = hrc_pkg::MaxDepth
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [30:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[2:0], counter[6:3], resource[11:7], amount[43:12], severity[45:44],
    // new_barrier[76:46], new_limit[107:77], parent_index[111:108],
    // parent_present[112], zero fill up to 119
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], held_now[33:2], peak_held[65:34], failures[97:66],
    // barrier_now[128:98], limit_now[159:129]
    output logic [159:0] m_axis_tdata
);

    localparam int unsigned CIW     = $clog2(NUM_COUNTERS);
    localparam int unsigned RIW     = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int unsigned ENTRIES = NUM_COUNTERS * NUM_RESOURCES;
    localparam int unsigned AW      = $clog2(ENTRIES);
    localparam int unsigned DW      = $clog2(MAX_DEPTH + 1);
    localparam int unsigned LW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // Sequencer states.
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_EXEC  = 4'd4;
    localparam logic [3:0] S_UNRL  = 4'd5;
    localparam logic [3:0] S_FRD   = 4'd6;
    localparam logic [3:0] S_FWAIT = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_LVL   = 4'd9;

    // Input field unpacking.
    logic [2:0]  w_mode;
    logic [3:0]  w_counter;
    logic [4:0]  w_resource;
    logic [31:0] w_amount;
    logic [1:0]  w_sev;
    assign w_mode     = s_axis_tdata[2:0];
    assign w_counter  = s_axis_tdata[6:3];
    assign w_resource = s_axis_tdata[11:7];
    assign w_amount   = s_axis_tdata[43:12];
    assign w_sev      = s_axis_tdata[45:44];

    logic [3:0]   r_state, n_state;
    logic [30:0]  r_max;
    logic [AW-1:0] r_clr;
    logic [2:0]   r_mode;
    logic [CIW-1:0] r_c0, r_cur;
    logic [RIW-1:0] r_res;
    logic [31:0]  r_amt;
    logic [1:0]   r_sev;
    logic [30:0]  r_nb, r_nl;
    logic [3:0]   r_pidx;
    logic         r_ppres;
    logic [1:0]   r_status;
    logic [DW-1:0] r_depth;
    logic [DW-1:0] r_n;
    logic         r_bad;
    logic [CIW-1:0] r_idx [MAX_DEPTH];
    logic [31:0]  r_old [MAX_DEPTH];
    logic [CIW-1:0] r_par [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] r_pv;
    logic [159:0] r_out;
    logic         r_ov;

    // Entry memories.
    logic          w_we_h, w_we_p, w_we_f, w_we_l;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_wh, w_wp, w_wf, w_rh, w_rp, w_rf;
    logic [30:0]   w_wb, w_wl, w_rb, w_rl;

    hrc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_held (
        .i_clk(i_clk), .i_we(w_we_h), .i_waddr(w_waddr), .i_wdata(w_wh),
        .i_raddr(w_raddr), .o_rdata(w_rh));
    hrc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_peak (
        .i_clk(i_clk), .i_we(w_we_p), .i_waddr(w_waddr), .i_wdata(w_wp),
        .i_raddr(w_raddr), .o_rdata(w_rp));
    hrc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_fail (
        .i_clk(i_clk), .i_we(w_we_f), .i_waddr(w_waddr), .i_wdata(w_wf),
        .i_raddr(w_raddr), .o_rdata(w_rf));
    hrc_ram #(.WIDTH(31), .DEPTH(ENTRIES)) u_barr (
        .i_clk(i_clk), .i_we(w_we_l), .i_waddr(w_waddr), .i_wdata(w_wb),
        .i_raddr(w_raddr), .o_rdata(w_rb));
    hrc_ram #(.WIDTH(31), .DEPTH(ENTRIES)) u_lim (
        .i_clk(i_clk), .i_we(w_we_l), .i_waddr(w_waddr), .i_wdata(w_wl),
        .i_raddr(w_raddr), .o_rdata(w_rl));

    // Registered copy of the entry read, so the compare starts from a register.
    logic [31:0] r_h, r_p, r_f;
    logic [30:0] r_b, r_l;

    // Parent lookup of the counter in work.
    logic           w_has_up;
    logic [CIW-1:0] w_up;
    logic [3:0]     w_pv4;
    always_comb begin
        w_pv4    = 4'(r_par[r_cur]);
        w_up     = r_par[r_cur];
        w_has_up = r_pv[r_cur] && (32'(w_pv4) < NUM_COUNTERS || CIW > 4);
    end

    function automatic logic [AW-1:0] f_addr(logic [CIW-1:0] c, logic [RIW-1:0] r);
        f_addr = AW'(c) * AW'(NUM_RESOURCES) + AW'(r);
    endfunction

    // Shared add / subtract / compare unit on the registered entry.
    logic [32:0] w_sum33;
    logic [31:0] w_sum;
    logic        w_refuse;
    logic        w_clamp;
    logic [31:0] w_sub;
    always_comb begin
        w_sum33  = {1'b0, r_h} + {1'b0, r_amt};
        w_sum    = w_sum33[32] ? 32'hFFFF_FFFF : w_sum33[31:0];
        if (r_sev == hrc_pkg::SEV_FORCED) begin
            w_refuse = 1'b0;
        end else if (r_sev == hrc_pkg::SEV_SOFT) begin
            w_refuse = w_sum > {1'b0, r_l};
        end else begin
            w_refuse = (w_sum > {1'b0, r_b}) || (w_sum > {1'b0, r_l});
        end
        w_clamp = r_h < r_amt;
        w_sub   = w_clamp ? 32'd0 : r_h - r_amt;
    end

    logic w_notop;
    assign w_notop = (r_mode == hrc_pkg::MODE_FORCE_NT) || (r_mode == hrc_pkg::MODE_UNCH_NT);
    logic w_chain;
    assign w_chain = (r_mode == hrc_pkg::MODE_CHARGE) || (r_mode == hrc_pkg::MODE_UNCHARGE)
                     || w_notop;
    logic w_last;
    assign w_last = (32'(r_depth) + 1 >= MAX_DEPTH) || !w_has_up;

    logic [LW-1:0] w_nlow;
    assign w_nlow = LW'(r_n - DW'(1));

    // Memory port control.
    always_comb begin
        w_we_h = 1'b0; w_we_p = 1'b0; w_we_f = 1'b0; w_we_l = 1'b0;
        w_wh = w_sum; w_wp = w_sum; w_wf = r_f + 32'd1;
        w_wb = r_nb; w_wl = r_nl;
        w_waddr = f_addr(r_cur, r_res);
        w_raddr = f_addr(r_cur, r_res);
        unique case (r_state)
            S_CLEAR: begin
                w_waddr = r_clr;
                w_we_h = 1'b1; w_we_p = 1'b1; w_we_f = 1'b1; w_we_l = 1'b1;
                w_wh = '0; w_wp = '0; w_wf = '0;
                w_wb = hrc_pkg::MASK31; w_wl = hrc_pkg::MASK31;
            end
            S_LVL: begin
                // Set limits writes both tables at the addressed entry.
                w_we_l = (r_mode == hrc_pkg::MODE_SET_LIMITS);
            end
            S_FRD, S_FWAIT, S_OUT, S_IDLE, S_WAIT, S_RD: begin
                if (r_state == S_FRD || r_state == S_FWAIT) begin
                    w_raddr = f_addr(r_c0, r_res);
                end
            end
            S_EXEC: begin
                if (r_mode == hrc_pkg::MODE_CHARGE) begin
                    if (w_refuse) begin
                        w_we_f = (r_f != 32'hFFFF_FFFF);
                    end else begin
                        w_we_h = 1'b1;
                        w_we_p = w_sum > r_p;
                    end
                end else if (r_mode == hrc_pkg::MODE_FORCE_NT) begin
                    w_we_h = w_has_up;
                    w_we_p = w_has_up && (w_sum > r_p);
                end else if (r_mode == hrc_pkg::MODE_UNCHARGE) begin
                    w_we_h = 1'b1; w_wh = w_sub;
                end else if (r_mode == hrc_pkg::MODE_UNCH_NT) begin
                    w_we_h = w_has_up; w_wh = w_sub;
                end else begin
                    w_we_h = 1'b0;
                end
            end
            S_UNRL: begin
                w_waddr = f_addr(r_idx[w_nlow], r_res);
                w_we_h  = (r_n != '0);
                w_wh    = r_old[w_nlow];
            end
            default: begin
                w_we_h = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (32'(r_clr) == ENTRIES - 1) n_state = S_IDLE;
            S_IDLE: if (s_axis_tvalid) begin
                if (32'(w_counter) >= NUM_COUNTERS || 32'(w_resource) >= NUM_RESOURCES) begin
                    n_state = S_OUT;
                end else n_state = S_LVL;
            end
            S_LVL: begin
                // An oversized charge skips the walk and only reads the entry.
                if (r_mode == hrc_pkg::MODE_CHARGE && {1'b0, r_max} < r_amt) begin
                    n_state = S_FRD;
                end else if (w_chain) n_state = S_RD;
                else n_state = S_FRD;
            end
            S_RD:   n_state = S_WAIT;
            S_WAIT: n_state = S_EXEC;
            S_EXEC: begin
                if (r_mode == hrc_pkg::MODE_CHARGE && w_refuse) n_state = S_UNRL;
                else if (w_last) n_state = S_FRD;
                else n_state = S_RD;
            end
            S_UNRL: if (r_n == '0) n_state = S_FRD;
            S_FRD:   n_state = S_FWAIT;
            S_FWAIT: n_state = S_OUT;
            S_OUT:   if (!r_ov) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_max   <= hrc_pkg::MASK31;
            r_pv    <= '0;
            r_ov    <= 1'b0;
            for (int k = 0; k < NUM_COUNTERS; k++) r_par[k] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_max <= i_cfg_wdata;
            r_h <= w_rh; r_p <= w_rp; r_f <= w_rf; r_b <= w_rb; r_l <= w_rl;
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + AW'(1);
                S_IDLE: if (s_axis_tvalid) begin
                    r_mode   <= w_mode;
                    r_c0     <= CIW'(w_counter);
                    r_cur    <= CIW'(w_counter);
                    r_res    <= RIW'(w_resource);
                    r_amt    <= w_amount;
                    r_sev    <= w_sev;
                    r_nb     <= s_axis_tdata[76:46];
                    r_nl     <= s_axis_tdata[107:77];
                    r_pidx   <= s_axis_tdata[111:108];
                    r_ppres  <= s_axis_tdata[112];
                    r_depth  <= '0;
                    r_n      <= '0;
                    r_bad    <= 32'(w_counter) >= NUM_COUNTERS
                                || 32'(w_resource) >= NUM_RESOURCES;
                    r_status <= (32'(w_counter) >= NUM_COUNTERS
                                || 32'(w_resource) >= NUM_RESOURCES)
                                ? hrc_pkg::ST_INVALID : hrc_pkg::ST_OK;
                end
                S_LVL: begin
                    if (r_mode == hrc_pkg::MODE_CHARGE && {1'b0, r_max} < r_amt) begin
                        r_status <= hrc_pkg::ST_INVALID;
                    end
                    if (r_mode == hrc_pkg::MODE_SET_PARENT) begin
                        r_par[r_c0] <= CIW'(r_pidx);
                        r_pv[r_c0]  <= r_ppres && (32'(r_pidx) < NUM_COUNTERS);
                    end
                end
                S_EXEC: begin
                    if (r_mode == hrc_pkg::MODE_CHARGE) begin
                        if (w_refuse) r_status <= hrc_pkg::ST_REFUSED;
                        else begin
                            r_idx[LW'(r_n)] <= r_cur;
                            r_old[LW'(r_n)] <= r_h;
                            r_n <= r_n + DW'(1);
                        end
                    end else if (r_mode == hrc_pkg::MODE_UNCHARGE
                                 || (r_mode == hrc_pkg::MODE_UNCH_NT && w_has_up)) begin
                        if (w_clamp) r_status <= hrc_pkg::ST_CLAMPED;
                    end
                    r_depth <= r_depth + DW'(1);
                    if (w_has_up) r_cur <= w_up;
                end
                S_UNRL: if (r_n != '0) r_n <= r_n - DW'(1);
                S_FWAIT: begin
                    if (r_bad) r_out <= {158'd0, hrc_pkg::ST_INVALID};
                    else r_out <= {w_rl, w_rb, w_rf, w_rp, w_rh, r_status};
                    r_ov <= 1'b1;
                end
                S_OUT: begin
                    if (r_bad && !r_ov) begin
                        r_out <= {158'd0, hrc_pkg::ST_INVALID};
                    end
                end
                default: r_n <= r_n;
            endcase
            if (r_state == S_IDLE && s_axis_tvalid && (32'(w_counter) >= NUM_COUNTERS
                || 32'(w_resource) >= NUM_RESOURCES)) begin
                r_out <= {158'd0, hrc_pkg::ST_INVALID};
                r_ov  <= 1'b1;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

endmodule

>>> rtl/hrc_ram.sv
// ----------------------------------------------------------------------------
// hrc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hrc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
